/* rtl/core/hcurve_pkg.sv */
// Shared types, constants and helpers for the Hermite curve core.
`default_nettype none
package hcurve_pkg;

  // Internal width of curve coordinates (guide points reach about 33 bits).
  localparam int W = 36;
  // Width of one chord length.
  localparam int LW = 38;
  // Width of the accumulated length.
  localparam int AW = 48;

  localparam logic [16:0] ONE_Q16 = 17'h10000;
  // Reciprocal of three for exact truncating division of a 32-bit magnitude.
  localparam logic [33:0] RECIP3 = 34'h0AAAAAAAB;

  typedef enum logic [1:0] {
    OP_POINT   = 2'd0,
    OP_LENGTH  = 2'd1,
    OP_AT_DIST = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    REG_START_X     = 3'd0,
    REG_START_Y     = 3'd1,
    REG_START_VEL_X = 3'd2,
    REG_START_VEL_Y = 3'd3,
    REG_END_X       = 3'd4,
    REG_END_Y       = 3'd5,
    REG_END_VEL_X   = 3'd6,
    REG_END_VEL_Y   = 3'd7
  } reg_e;

  function automatic logic signed [W-1:0] ext32(input logic [31:0] v);
    return $signed({{(W-32){v[31]}}, v});
  endfunction

  // Left operand index of each de Casteljau step: three, two, then one lerp.
  function automatic logic [1:0] step_lo(input logic [2:0] k);
    logic [1:0] j;
    case (k)
      3'd0: j = 2'd0;
      3'd1: j = 2'd1;
      3'd2: j = 2'd2;
      3'd3: j = 2'd0;
      3'd4: j = 2'd1;
      default: j = 2'd0;
    endcase
    return j;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [W:0] v);
    logic [31:0] r;
    if (v > $signed({{(W-30){1'b0}}, 31'h7FFFFFFF})) begin
      r = 32'h7FFFFFFF;
    end else if (v < $signed({{(W-30){1'b1}}, 31'h0})) begin
      r = 32'h80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/hermite_curve_point_and_arc_length_core.sv */
// Top level: cubic Hermite curve point, chord-sum length and point at distance.
// Ops 1 and 2 work chord by chord: each chord takes a curve point from 12 multiply-add
// steps on one shared multiplier, then a 32-step square root; op 2 adds a fraction
// division and a final interpolation when the distance is found.
// Takes one item at a time; the next is taken once the result moves to the output.
// Reset clears the curve registers to zero and empties the output.
`default_nettype none
module hermite_curve_point_and_arc_length_core #(
  parameter int unsigned MAX_SUBDIVISIONS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [16:0] param_t_i,
  input  logic [31:0] distance_i,
  input  logic [10:0] subdivisions_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] point_x_o,
  output logic [31:0] point_y_o,
  output logic [31:0] curve_length_o,
  output logic        found_o
);
  import hcurve_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_GMUL, S_GSET, S_BRANCH, S_DIV, S_TSTEP, S_EVLD, S_EVMUL, S_EVADD,
    S_CABS, S_CNORM, S_SQX, S_SQY, S_SQI, S_SQRT, S_CACC, S_FMUL, S_FADD, S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;

  logic [31:0]            cfg_q [8];
  op_e                    op_q;
  logic [16:0]            t_q;
  logic [31:0]            dist_q;
  logic [10:0]            n_q;
  logic signed [W-1:0]    g_q [4];
  logic [2:0]             k_q;
  logic                   dim_q;
  logic signed [W-1:0]    wx_q [4];
  logic signed [W-1:0]    wy_q [4];
  logic signed [W-1:0]    ax_q, ay_q;
  logic signed [71:0]     prod_q;
  logic [W:0]             ux_q, uy_q;
  logic [2:0]             sh_q;
  logic [61:0]            sq_q;
  logic [63:0]            rad_q, root_q, bit_q;
  logic [4:0]             cnt_q;
  logic [AW-1:0]          acc_q;
  logic [39:0]            rem_q;
  logic [16:0]            quo_q;
  logic [LW-1:0]          dvs_q;
  logic                   fdiv_q;
  logic [16:0]            q0_q;
  logic [10:0]            r0_q;
  logic [11:0]            rr_q;
  logic [10:0]            i_q;
  logic [31:0]            res_x_q, res_y_q;
  logic                   res_f_q;
  logic [31:0]            point_x_q, point_y_q, len_q;
  logic                   found_q;

  // Shared multiplier operands
  logic signed [37:0]     mul_a;
  logic signed [33:0]     mul_b;
  logic signed [71:0]     prod_d;

  logic                   accept_in, take_done;
  logic [1:0]             j_lo, j_hi;
  logic signed [W-1:0]    w_lo, w_hi;
  logic signed [W:0]      w_diff, f_diff;
  logic signed [71:0]     rnd_w;
  logic signed [W-1:0]    w_new;
  logic signed [W:0]      f_new;
  logic [31:0]            vsel;
  logic [32:0]            vmag;
  logic signed [W-1:0]    vd3;
  logic signed [W:0]      dx, dy;
  logic [39:0]            rem_sh, div_rem_d;
  logic [16:0]            quo_sh, div_quo_d;
  logic [63:0]            root_plus;
  logic [LW-1:0]          chord_len;
  logic [AW-1:0]          acc_d;
  logic                   hit;
  logic [10:0]            n_in;
  logic [16:0]            t_sum;
  logic [11:0]            r_sum;

  assign accept_in = in_valid_i && (state_q == S_IDLE);
  assign take_done = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = (state_q != S_IDLE);

  // Datapath helpers
  always_comb begin
    j_lo   = step_lo(k_q);
    j_hi   = j_lo + 2'd1;
    w_lo   = dim_q ? wy_q[j_lo] : wx_q[j_lo];
    w_hi   = dim_q ? wy_q[j_hi] : wx_q[j_hi];
    w_diff = {w_hi[W-1], w_hi} - {w_lo[W-1], w_lo};
    f_diff = dim_q ? ({wy_q[0][W-1], wy_q[0]} - {ay_q[W-1], ay_q})
                   : ({wx_q[0][W-1], wx_q[0]} - {ax_q[W-1], ax_q});
    rnd_w  = (prod_q + 72'sd32768) >>> 16;
    w_new  = w_lo + $signed(rnd_w[W-1:0]);
    f_new  = (dim_q ? {ay_q[W-1], ay_q} : {ax_q[W-1], ax_q}) + $signed(rnd_w[W:0]);

    case (k_q[1:0])
      2'd0: vsel = cfg_q[REG_START_VEL_X];
      2'd1: vsel = cfg_q[REG_START_VEL_Y];
      2'd2: vsel = cfg_q[REG_END_VEL_X];
      default: vsel = cfg_q[REG_END_VEL_Y];
    endcase
    vmag = vsel[31] ? (33'd0 - {1'b1, vsel}) : {1'b0, vsel};
    vd3  = vsel[31] ? -$signed({5'b0, prod_q[63:33]}) : $signed({5'b0, prod_q[63:33]});

    dx = {wx_q[0][W-1], wx_q[0]} - {ax_q[W-1], ax_q};
    dy = {wy_q[0][W-1], wy_q[0]} - {ay_q[W-1], ay_q};

    rem_sh = {rem_q[38:0], quo_q[16]};
    quo_sh = {quo_q[15:0], 1'b0};
    if (rem_sh >= {2'b0, dvs_q}) begin
      div_rem_d = rem_sh - {2'b0, dvs_q};
      div_quo_d = quo_sh | 17'd1;
    end else begin
      div_rem_d = rem_sh;
      div_quo_d = quo_sh;
    end

    root_plus = root_q + bit_q;
    chord_len = {{(LW-32){1'b0}}, root_q[31:0]} << sh_q;
    acc_d     = acc_q + {{(AW-LW){1'b0}}, chord_len};
    hit       = (op_q == OP_AT_DIST) && (acc_d > {{(AW-32){1'b0}}, dist_q});

    n_in  = (subdivisions_i == 11'd0) ? 11'd1 : subdivisions_i;
    t_sum = t_q + q0_q;
    r_sum = rr_q + {1'b0, r0_q};
  end

  // One multiplier, operands picked by the sequencer
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_GMUL: begin
        mul_a = $signed({5'b0, vmag});
        mul_b = $signed(RECIP3);
      end
      S_EVMUL: begin
        mul_a = 38'(w_diff);
        mul_b = $signed({17'b0, t_q});
      end
      S_SQX: begin
        mul_a = $signed({7'b0, ux_q[30:0]});
        mul_b = $signed({3'b0, ux_q[30:0]});
      end
      S_SQY: begin
        mul_a = $signed({7'b0, uy_q[30:0]});
        mul_b = $signed({3'b0, uy_q[30:0]});
      end
      S_FMUL: begin
        mul_a = 38'(f_diff);
        mul_b = $signed({18'b0, quo_q[15:0]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = mul_a * mul_b;
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_GMUL;
      S_GMUL:   state_d = S_GSET;
      S_GSET:   state_d = (k_q == 3'd3) ? S_BRANCH : S_GMUL;
      S_BRANCH: begin
        case (op_q)
          OP_POINT:   state_d = S_EVLD;
          OP_LENGTH:  state_d = S_DIV;
          OP_AT_DIST: state_d = S_DIV;
          default:    state_d = S_DONE;
        endcase
      end
      S_DIV:    if (cnt_q == 5'd0) state_d = fdiv_q ? S_FMUL : S_TSTEP;
      S_TSTEP:  state_d = S_EVLD;
      S_EVLD:   state_d = S_EVMUL;
      S_EVMUL:  state_d = S_EVADD;
      S_EVADD: begin
        if (k_q != 3'd5 || !dim_q) begin
          state_d = S_EVMUL;
        end else begin
          state_d = (op_q == OP_POINT) ? S_DONE : S_CABS;
        end
      end
      S_CABS:   state_d = S_CNORM;
      S_CNORM:  if (ux_q[W:31] == '0 && uy_q[W:31] == '0) state_d = S_SQX;
      S_SQX:    state_d = S_SQY;
      S_SQY:    state_d = S_SQI;
      S_SQI:    state_d = S_SQRT;
      S_SQRT:   if (cnt_q == 5'd0) state_d = S_CACC;
      S_CACC: begin
        if (hit) begin
          state_d = S_DIV;
        end else if (i_q == n_q - 11'd1) begin
          state_d = S_DONE;
        end else begin
          state_d = S_TSTEP;
        end
      end
      S_FMUL:   state_d = S_FADD;
      S_FADD:   state_d = dim_q ? S_DONE : S_FMUL;
      S_DONE:   if (take_done) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int r = 0; r < 8; r++) cfg_q[r] <= '0;
    end else begin
      state_q <= state_d;
      if (take_done) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i && !cfg_index_i[3]) cfg_q[cfg_index_i[2:0]] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept_in) begin
          op_q   <= op_e'(op_i);
          t_q    <= (param_t_i > ONE_Q16) ? ONE_Q16 : param_t_i;
          dist_q <= distance_i;
          n_q    <= (32'(n_in) > MAX_SUBDIVISIONS) ? 11'(MAX_SUBDIVISIONS) : n_in;
          k_q    <= 3'd0;
        end
      end
      S_GMUL: prod_q <= prod_d;
      S_GSET: begin
        // guide points: P0 + V0/3 and P3 - V3/3
        case (k_q[1:0])
          2'd0: g_q[0] <= ext32(cfg_q[REG_START_X]) + vd3;
          2'd1: g_q[1] <= ext32(cfg_q[REG_START_Y]) + vd3;
          2'd2: g_q[2] <= ext32(cfg_q[REG_END_X]) - vd3;
          default: g_q[3] <= ext32(cfg_q[REG_END_Y]) - vd3;
        endcase
        k_q <= k_q + 3'd1;
      end
      S_BRANCH: begin
        acc_q   <= '0;
        res_x_q <= '0;
        res_y_q <= '0;
        res_f_q <= 1'b0;
        ax_q    <= ext32(cfg_q[REG_START_X]);
        ay_q    <= ext32(cfg_q[REG_START_Y]);
        i_q     <= '0;
        rr_q    <= '0;
        // step size 65536 / n through the shared divider
        rem_q   <= '0;
        quo_q   <= ONE_Q16;
        dvs_q   <= {{(LW-11){1'b0}}, n_q};
        cnt_q   <= 5'd16;
        fdiv_q  <= 1'b0;
        if (op_q != OP_POINT) t_q <= '0;
      end
      S_DIV: begin
        rem_q <= div_rem_d;
        quo_q <= div_quo_d;
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          q0_q  <= div_quo_d;
          r0_q  <= div_rem_d[10:0];
          dim_q <= 1'b0;
        end
      end
      S_TSTEP: begin
        if (r_sum >= {1'b0, n_q}) begin
          rr_q <= r_sum - {1'b0, n_q};
          t_q  <= t_sum + 17'd1;
        end else begin
          rr_q <= r_sum;
          t_q  <= t_sum;
        end
      end
      S_EVLD: begin
        wx_q[0] <= ext32(cfg_q[REG_START_X]);
        wx_q[1] <= g_q[0];
        wx_q[2] <= g_q[2];
        wx_q[3] <= ext32(cfg_q[REG_END_X]);
        wy_q[0] <= ext32(cfg_q[REG_START_Y]);
        wy_q[1] <= g_q[1];
        wy_q[2] <= g_q[3];
        wy_q[3] <= ext32(cfg_q[REG_END_Y]);
        k_q     <= 3'd0;
        dim_q   <= 1'b0;
      end
      S_EVMUL: prod_q <= prod_d;
      S_EVADD: begin
        if (dim_q) begin
          wy_q[j_lo] <= w_new;
        end else begin
          wx_q[j_lo] <= w_new;
        end
        if (k_q == 3'd5) begin
          k_q   <= 3'd0;
          dim_q <= !dim_q;
          // only a point request reports the evaluated point directly
          if (dim_q && op_q == OP_POINT) begin
            res_x_q <= sat32({wx_q[0][W-1], wx_q[0]});
            res_y_q <= sat32({w_new[W-1], w_new});
            res_f_q <= 1'b1;
          end
        end else begin
          k_q <= k_q + 3'd1;
        end
      end
      S_CABS: begin
        ux_q <= dx[W] ? (W+1)'(-dx) : dx;
        uy_q <= dy[W] ? (W+1)'(-dy) : dy;
        sh_q <= '0;
      end
      S_CNORM: begin
        if (ux_q[W:31] != '0 || uy_q[W:31] != '0) begin
          ux_q <= ux_q >> 1;
          uy_q <= uy_q >> 1;
          sh_q <= sh_q + 3'd1;
        end
      end
      S_SQX: prod_q <= prod_d;
      S_SQY: begin
        sq_q   <= prod_q[61:0];
        prod_q <= prod_d;
      end
      S_SQI: begin
        rad_q  <= {2'b0, sq_q} + {1'b0, prod_q[62:0]};
        root_q <= '0;
        bit_q  <= 64'h4000000000000000;
        cnt_q  <= 5'd31;
      end
      S_SQRT: begin
        if (rad_q >= root_plus) begin
          rad_q  <= rad_q - root_plus;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
        cnt_q <= cnt_q - 5'd1;
      end
      S_CACC: begin
        acc_q <= acc_d;
        if (hit) begin
          // fraction of the chord: (distance - before) * 65536 / chord
          rem_q  <= {8'b0, dist_q - acc_q[31:0]};
          quo_q  <= '0;
          dvs_q  <= chord_len;
          cnt_q  <= 5'd15;
          fdiv_q <= 1'b1;
        end else begin
          ax_q <= wx_q[0];
          ay_q <= wy_q[0];
          i_q  <= i_q + 11'd1;
          if (i_q == n_q - 11'd1) res_f_q <= (op_q == OP_LENGTH);
        end
      end
      S_FMUL: prod_q <= prod_d;
      S_FADD: begin
        if (dim_q) begin
          res_y_q <= sat32(f_new);
          res_f_q <= 1'b1;
        end else begin
          res_x_q <= sat32(f_new);
        end
        dim_q <= 1'b1;
      end
      S_DONE: begin
        if (take_done) begin
          point_x_q <= res_x_q;
          point_y_q <= res_y_q;
          len_q     <= (acc_q[AW-1:32] != '0) ? 32'hFFFFFFFF : acc_q[31:0];
          found_q   <= res_f_q;
        end
      end
      default: begin
        prod_q <= prod_q;
      end
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign point_x_o      = point_x_q;
  assign point_y_o      = point_y_q;
  assign curve_length_o = len_q;
  assign found_o        = found_q;

endmodule
`default_nettype wire
